@@ rtl/ray_box_slab_intersect_top_defines.svh @@
// Assertion macros for the ray against box slab test block.
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_DEFINES_SVH

// check a condition at every clock edge out of reset
`define RBSI_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// check a consequence in the same cycle
`define RBSI_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// check a consequence in the next cycle
`define RBSI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rbsi_pkg.sv @@
// Types, constants and saturating arithmetic for the ray against box slab test.
package rbsi_pkg;

   localparam int CW     = 32;
   localparam int FB     = 16;
   localparam int QW     = 2 * FB + 1;
   localparam int PW     = 2 * CW;
   localparam int IO_W   = 32;
   localparam int DIST_W = 31;
   localparam int REQ_W  = 12 * IO_W;
   localparam int RSP_W  = 136;

   localparam logic [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] ONE  = {{(CW-1){1'b0}}, 1'b1};

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef logic [2:0][CW-1:0] rbsi_vec_type;
   typedef logic [2:0][QW-1:0] rbsi_quo_type;
   typedef logic [2:0][PW-1:0] rbsi_prod_type;

   typedef struct packed {
      rbsi_vec_type o;
      rbsi_vec_type d;
      rbsi_vec_type mn;
      rbsi_vec_type mx;
      rbsi_vec_type dmn;
      rbsi_vec_type dmx;
   } rbsi_item_type;

   function automatic logic [CW-1:0] mag_of(input logic [CW-1:0] a);
      return a[CW-1] ? ('0 - a) : a;
   endfunction

   function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {a[CW-1], a} - {b[CW-1], b};
      if (s[CW] != s[CW-1]) return s[CW] ? VMIN : VMAX;
      return s[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {a[CW-1], a} + {b[CW-1], b};
      if (s[CW] != s[CW-1]) return s[CW] ? VMIN : VMAX;
      return s[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] sat_prod(input logic neg, input logic [PW-1:0] p);
      logic [PW-1:0] sh;
      logic          hi_any;
      sh     = p >> FB;
      hi_any = |sh[PW-1:CW];
      if (!neg) return (hi_any || sh[CW-1]) ? VMAX : sh[CW-1:0];
      return (hi_any || (sh[CW-1] && (|sh[CW-2:0]))) ? VMIN : ('0 - sh[CW-1:0]);
   endfunction

   function automatic logic [CW-1:0] recip_of(input logic zero, input logic neg,
                                               input logic [QW-1:0] q);
      if (zero) return VMAX;
      if (!neg) return (|q[QW-1:CW-1]) ? VMAX : q[CW-1:0];
      return (|q[QW-1:CW-1]) ? VMIN : ('0 - q[CW-1:0]);
   endfunction

endpackage

@@ rtl/rbsi_recip.sv @@
// Pipelined restoring divider forming the scaled reciprocal magnitude on three axes.
module rbsi_recip (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  rbsi_pkg::rbsi_item_type in_item,
   output logic                   out_valid,
   output rbsi_pkg::rbsi_quo_type  out_quo,
   output rbsi_pkg::rbsi_item_type out_item
);

   logic [rbsi_pkg::QW-1:0]  vld_ff;
   logic [rbsi_pkg::QW-1:0]  vld_in;
   rbsi_pkg::rbsi_vec_type   rem_ff  [rbsi_pkg::QW];
   rbsi_pkg::rbsi_vec_type   rem_in  [rbsi_pkg::QW];
   rbsi_pkg::rbsi_vec_type   dvs_ff  [rbsi_pkg::QW];
   rbsi_pkg::rbsi_vec_type   dvs_in  [rbsi_pkg::QW];
   rbsi_pkg::rbsi_quo_type   quo_ff  [rbsi_pkg::QW];
   rbsi_pkg::rbsi_quo_type   quo_in  [rbsi_pkg::QW];
   rbsi_pkg::rbsi_item_type  item_ff [rbsi_pkg::QW];
   rbsi_pkg::rbsi_item_type  item_in [rbsi_pkg::QW];

   always_comb begin
      logic [rbsi_pkg::CW-1:0] prev_rem;
      logic [rbsi_pkg::CW-1:0] prev_m;
      logic [rbsi_pkg::QW-1:0] prev_q;
      logic [rbsi_pkg::CW:0]   shifted;
      logic [rbsi_pkg::CW:0]   diff;
      logic                    ge;
      for (int s = 0; s < rbsi_pkg::QW; s++) begin
         if (s == 0) begin
            vld_in[s]  = in_valid;
            item_in[s] = in_item;
         end else begin
            vld_in[s]  = vld_ff[s-1];
            item_in[s] = item_ff[s-1];
         end
         for (int a = 0; a < 3; a++) begin
            if (s == 0) begin
               prev_rem = '0;
               prev_q   = '0;
               prev_m   = rbsi_pkg::mag_of(in_item.d[a]);
               shifted  = {prev_rem, 1'b1};
            end else begin
               prev_rem = rem_ff[s-1][a];
               prev_q   = quo_ff[s-1][a];
               prev_m   = dvs_ff[s-1][a];
               shifted  = {prev_rem, 1'b0};
            end
            diff          = shifted - {1'b0, prev_m};
            ge            = (shifted >= {1'b0, prev_m});
            rem_in[s][a]  = ge ? diff[rbsi_pkg::CW-1:0] : shifted[rbsi_pkg::CW-1:0];
            quo_in[s][a]  = {prev_q[rbsi_pkg::QW-2:0], ge};
            dvs_in[s][a]  = prev_m;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         dvs_ff  <= dvs_in;
         quo_ff  <= quo_in;
         item_ff <= item_in;
      end
   end

   assign out_valid = vld_ff[rbsi_pkg::QW-1];
   assign out_quo   = quo_ff[rbsi_pkg::QW-1];
   assign out_item  = item_ff[rbsi_pkg::QW-1];

endmodule

@@ rtl/ray_box_slab_intersect_top.sv @@
// Top level of the ray against axis-aligned box slab test pipeline.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/req_tready | req_tdata  (384 bits)
//  rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata  (136 bits)
//
// One test enters per cycle unless the pipeline is stalled. Stages: input register,
// 33 reciprocal divider stages, 9 arithmetic stages ending in the output register.
// The divider chain, one quotient bit per stage, sets the depth.
// Reset clears every valid bit; payload registers are not reset.
// A held result stalls the whole pipeline in place; nothing is dropped or repeated.
`include "ray_box_slab_intersect_top_defines.svh"

module ray_box_slab_intersect_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  logic [rbsi_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // hit, distance, point_x, point_y, point_z, normal_axis, normal_negative, zero pad
   output logic [rbsi_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int CW = rbsi_pkg::CW;
   localparam int PW = rbsi_pkg::PW;

   logic adv;

   logic v0_ff, va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff, vi_ff;
   logic dv_vld;
   rbsi_pkg::rbsi_quo_type  dv_quo;
   rbsi_pkg::rbsi_item_type dv_item;

   rbsi_pkg::rbsi_item_type item0_ff, item0_in;
   rbsi_pkg::rbsi_item_type itema_ff, itemb_ff, itemc_ff, itemd_ff;
   rbsi_pkg::rbsi_vec_type  ra_ff, ra_in;
   rbsi_pkg::rbsi_prod_type pl_ff, pl_in, ph_ff, ph_in;
   logic [2:0]              nl_ff, nl_in, nh_ff, nh_in;
   rbsi_pkg::rbsi_vec_type  lo_ff, lo_in, hi_ff, hi_in;
   logic                    hitd_ff, hitd_in;
   logic [CW-1:0]           td_ff, td_in;
   rbsi_pkg::rbsi_prod_type pt_ff, pt_in;
   logic [2:0]              nt_ff, nt_in;
   logic                    hite_ff;
   logic [CW-1:0]           te_ff;
   rbsi_pkg::rbsi_vec_type  oe_ff, mne_ff, mxe_ff;
   rbsi_pkg::rbsi_vec_type  pf_ff, pf_in, cf_ff, cf_in, ef_ff, ef_in;
   logic                    hitf_ff;
   logic [CW-1:0]           tf_ff;
   rbsi_pkg::rbsi_vec_type  offg_ff, offg_in, eg_ff, pg_ff;
   logic                    hitg_ff;
   logic [CW-1:0]           tg_ff;
   logic [5:0][PW-1:0]      xh_ff, xh_in;
   logic [2:0]              nzh_ff, nzh_in;
   rbsi_pkg::rbsi_vec_type  ph2_ff;
   logic                    hith_ff;
   logic [CW-1:0]           th_ff;
   logic [rbsi_pkg::RSP_W-1:0] out_ff, out_in;

   assign adv        = !vi_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vi_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      logic [CW-1:0] o, d, mn, mx;
      for (int a = 0; a < 3; a++) begin
         o  = req_tdata[a*rbsi_pkg::IO_W +: CW];
         d  = req_tdata[(3+a)*rbsi_pkg::IO_W +: CW];
         mn = req_tdata[(6+a)*rbsi_pkg::IO_W +: CW];
         mx = req_tdata[(9+a)*rbsi_pkg::IO_W +: CW];
         item0_in.o[a]   = o;
         item0_in.d[a]   = d;
         item0_in.mn[a]  = mn;
         item0_in.mx[a]  = mx;
         item0_in.dmn[a] = rbsi_pkg::sat_sub(mn, o);
         item0_in.dmx[a] = rbsi_pkg::sat_sub(mx, o);
      end
   end

   rbsi_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v0_ff),
      .in_item   (item0_ff),
      .out_valid (dv_vld),
      .out_quo   (dv_quo),
      .out_item  (dv_item)
   );

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         ra_in[a] = rbsi_pkg::recip_of(dv_item.d[a] == '0, dv_item.d[a][CW-1], dv_quo[a]);
         pl_in[a] = PW'(rbsi_pkg::mag_of(itema_ff.dmn[a])) * PW'(rbsi_pkg::mag_of(ra_ff[a]));
         ph_in[a] = PW'(rbsi_pkg::mag_of(itema_ff.dmx[a])) * PW'(rbsi_pkg::mag_of(ra_ff[a]));
         nl_in[a] = itema_ff.dmn[a][CW-1] ^ ra_ff[a][CW-1];
         nh_in[a] = itema_ff.dmx[a][CW-1] ^ ra_ff[a][CW-1];
      end
   end

   always_comb begin
      logic [CW-1:0] l, h;
      for (int a = 0; a < 3; a++) begin
         l = rbsi_pkg::sat_prod(nl_ff[a], pl_ff[a]);
         h = rbsi_pkg::sat_prod(nh_ff[a], ph_ff[a]);
         if ($signed(l) > $signed(h)) begin
            lo_in[a] = h;
            hi_in[a] = l;
         end else begin
            lo_in[a] = l;
            hi_in[a] = h;
         end
      end
   end

   always_comb begin
      logic signed [CW-1:0] tmin, tmax, t;
      logic                 miss;
      tmin = $signed(lo_ff[0]);
      tmax = $signed(hi_ff[0]);
      miss = 1'b0;
      for (int k = 1; k < 3; k++) begin
         if (tmin > $signed(hi_ff[k]) || $signed(lo_ff[k]) > tmax) miss = 1'b1;
         if ($signed(lo_ff[k]) > tmin) tmin = $signed(lo_ff[k]);
         if ($signed(hi_ff[k]) < tmax) tmax = $signed(hi_ff[k]);
      end
      if (tmax < 0) miss = 1'b1;
      t = (tmin >= 0) ? tmin : tmax;
      if (t < 0) miss = 1'b1;
      hitd_in = !miss;
      td_in   = t;
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pt_in[a] = PW'(rbsi_pkg::mag_of(itemd_ff.d[a])) * PW'(td_ff);
         nt_in[a] = itemd_ff.d[a][CW-1];
      end
   end

   always_comb begin
      logic [CW:0]   csum;
      logic [CW-1:0] es, eh;
      for (int a = 0; a < 3; a++) begin
         pf_in[a] = rbsi_pkg::sat_add(oe_ff[a], rbsi_pkg::sat_prod(nt_ff[a], pt_ff[a]));
         csum = {mne_ff[a][CW-1], mne_ff[a][CW-1], mne_ff[a][CW-1:1]}
              + {mxe_ff[a][CW-1], mxe_ff[a][CW-1], mxe_ff[a][CW-1:1]}
              + (CW+1)'(mne_ff[a][0] & mxe_ff[a][0]);
         cf_in[a] = csum[CW-1:0];
         es = rbsi_pkg::sat_sub(mxe_ff[a], mne_ff[a]);
         eh = {es[CW-1], es[CW-1:1]};
         ef_in[a] = ($signed(eh) < $signed(rbsi_pkg::ONE)) ? rbsi_pkg::ONE : eh;
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         offg_in[a] = rbsi_pkg::sat_sub(pf_ff[a], cf_ff[a]);
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         nzh_in[a] = !($signed(offg_ff[a]) > 0);
      end
      xh_in[0] = PW'(rbsi_pkg::mag_of(offg_ff[0])) * PW'(eg_ff[1]);
      xh_in[1] = PW'(rbsi_pkg::mag_of(offg_ff[1])) * PW'(eg_ff[0]);
      xh_in[2] = PW'(rbsi_pkg::mag_of(offg_ff[0])) * PW'(eg_ff[2]);
      xh_in[3] = PW'(rbsi_pkg::mag_of(offg_ff[2])) * PW'(eg_ff[0]);
      xh_in[4] = PW'(rbsi_pkg::mag_of(offg_ff[1])) * PW'(eg_ff[2]);
      xh_in[5] = PW'(rbsi_pkg::mag_of(offg_ff[2])) * PW'(eg_ff[1]);
   end

   always_comb begin
      logic [1:0] axis;
      logic       neg;
      if (xh_ff[0] > xh_ff[1] && xh_ff[2] > xh_ff[3]) begin
         axis = rbsi_pkg::AXIS_X;
         neg  = nzh_ff[0];
      end else if (xh_ff[4] > xh_ff[5]) begin
         axis = rbsi_pkg::AXIS_Y;
         neg  = nzh_ff[1];
      end else begin
         axis = rbsi_pkg::AXIS_Z;
         neg  = nzh_ff[2];
      end
      out_in = '0;
      if (hith_ff) begin
         out_in[0]      = 1'b1;
         out_in[31:1]   = th_ff[rbsi_pkg::DIST_W-1:0];
         out_in[63:32]  = ph2_ff[0];
         out_in[95:64]  = ph2_ff[1];
         out_in[127:96] = ph2_ff[2];
         out_in[129:128] = axis;
         out_in[130]    = neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
         vh_ff <= 1'b0;
         vi_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
         va_ff <= dv_vld;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
         vh_ff <= vg_ff;
         vi_ff <= vh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item0_ff <= item0_in;
         ra_ff    <= ra_in;
         itema_ff <= dv_item;
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
         nl_ff    <= nl_in;
         nh_ff    <= nh_in;
         itemb_ff <= itema_ff;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         itemc_ff <= itemb_ff;
         hitd_ff  <= hitd_in;
         td_ff    <= td_in;
         itemd_ff <= itemc_ff;
         pt_ff    <= pt_in;
         nt_ff    <= nt_in;
         hite_ff  <= hitd_ff;
         te_ff    <= td_ff;
         oe_ff    <= itemd_ff.o;
         mne_ff   <= itemd_ff.mn;
         mxe_ff   <= itemd_ff.mx;
         pf_ff    <= pf_in;
         cf_ff    <= cf_in;
         ef_ff    <= ef_in;
         hitf_ff  <= hite_ff;
         tf_ff    <= te_ff;
         offg_ff  <= offg_in;
         eg_ff    <= ef_ff;
         pg_ff    <= pf_ff;
         hitg_ff  <= hitf_ff;
         tg_ff    <= tf_ff;
         xh_ff    <= xh_in;
         nzh_ff   <= nzh_in;
         ph2_ff   <= pg_ff;
         hith_ff  <= hitg_ff;
         th_ff    <= tg_ff;
         out_ff   <= out_in;
      end
   end

   `RBSI_ASSERT_SAME(a_miss_zero, rsp_tvalid && !rsp_tdata[0], rsp_tdata == '0, "miss result not cleared")
   `RBSI_ASSERT_ALWAYS(a_axis_range, !rsp_tvalid || rsp_tdata[129:128] != 2'd3, "normal axis out of range")
   `RBSI_ASSERT_NEXT(a_stall_hold, !adv, $stable(dv_vld) && $stable(vh_ff), "pipeline moved while stalled")

endmodule
